FILE: rtl/brn_pkg.sv
`timescale 1ns / 1ps
package brn_pkg;

  // frame store geometry
  localparam int MAX_SRC_WIDTH  = 512;
  localparam int MAX_SRC_HEIGHT = 512;
  localparam int MAX_OUT_DIM    = 1024;
  localparam int COL_BITS       = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_SRC_HEIGHT);
  localparam int ADDR_BITS      = COL_BITS + ROW_BITS;
  localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  // source position divider: quotient bits and numerator bits shifted in
  localparam int QUOT_BITS  = 26;
  localparam int LOW_BITS   = QUOT_BITS - 16;
  localparam int NUM_BITS   = 21;
  localparam int REM_BITS   = 12;

  // result buffer
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR   = $clog2(FIFO_DEPTH);
  localparam int MATH_DEPTH = 7;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_SRC_WIDTH    = 3'd1,
    REG_SRC_HEIGHT   = 3'd2,
    REG_OUT_WIDTH    = 3'd3,
    REG_OUT_HEIGHT   = 3'd4,
    REG_SCALE        = 3'd5,
    REG_MEAN         = 3'd6,
    REG_INV_STD      = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  localparam logic [1:0] FMT_GRAY8 = 2'd0;
  localparam logic [1:0] FMT_BGR8  = 2'd1;

  typedef struct packed {
    logic [19:0]        pixel_index;
    logic signed [23:0] red_value;
    logic signed [23:0] green_value;
    logic signed [23:0] blue_value;
  } result_t;

  // clamp source dimension to [1, MAX_SRC_WIDTH]
  function automatic logic [9:0] clamp_src(input logic [9:0] v);
    logic [9:0] r;
    r = v;
    if (v == 10'd0) r = 10'd1;
    else if (v > 10'(MAX_SRC_WIDTH)) r = 10'(MAX_SRC_WIDTH);
    return r;
  endfunction

  // clamp output dimension to [1, MAX_OUT_DIM]
  function automatic logic [10:0] clamp_out(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > 11'(MAX_OUT_DIM)) r = 11'(MAX_OUT_DIM);
    return r;
  endfunction

endpackage

FILE: rtl/brn_in_if.sv
`timescale 1ns / 1ps
interface brn_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [9:0] x;
  logic [9:0] y;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;

  modport source (output valid, op, x, y, byte0, byte1, byte2, input ready);
  modport sink   (input valid, op, x, y, byte0, byte1, byte2, output ready);
endinterface

FILE: rtl/brn_out_if.sv
`timescale 1ns / 1ps
interface brn_out_if;
  logic               valid;
  logic               ready;
  logic [19:0]        pixel_index;
  logic signed [23:0] red_value;
  logic signed [23:0] green_value;
  logic signed [23:0] blue_value;

  modport source (output valid, pixel_index, red_value, green_value, blue_value,
                  input ready);
  modport sink   (input valid, pixel_index, red_value, green_value, blue_value,
                  output ready);
endinterface

FILE: rtl/brn_cfg_if.sv
`timescale 1ns / 1ps
interface brn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [62:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bilinear_resize_normalize_top.sv
`timescale 1ns / 1ps
// Bilinear resize with per-channel normalization. Load items write one RGB
// source pixel into a 512x512 single-port frame store (back to back while no
// sample holds the port; loads outside the frame are dropped). Sample items
// first pass a 27-stage pipelined divider that maps the output coordinate to
// a Q16 source position, then read the four neighbors in turn over the single
// store port, holding the next item until the last read issues. Blend and
// normalization follow in a 7-stage pipeline feeding an 8-entry result
// buffer; input stalls only when that buffer's credits run out or the store
// port is busy. Samples outside the output frame give no result. The store
// needs no clear: reading a pixel that was never loaded gives undefined data.
module bilinear_resize_normalize_top (
  input  logic      clk,
  input  logic      rst,
  brn_in_if.sink    in_item,
  brn_out_if.source out_item,
  brn_cfg_if.sink   cfg_wr
);

  localparam int DS = brn_pkg::QUOT_BITS;

  typedef struct packed {
    logic                              op;
    logic                              ok;
    logic [9:0]                        x;
    logic [9:0]                        y;
    logic [23:0]                       rgb;
    logic [brn_pkg::REM_BITS-1:0]      rx;
    logic [brn_pkg::REM_BITS-1:0]      ry;
    logic [brn_pkg::LOW_BITS-1:0]      lx;
    logic [brn_pkg::LOW_BITS-1:0]      ly;
    logic [brn_pkg::QUOT_BITS-1:0]     qx;
    logic [brn_pkg::QUOT_BITS-1:0]     qy;
  } dstage_t;

  // configuration registers
  logic [1:0]  pixel_format;
  logic [9:0]  src_width;
  logic [9:0]  src_height;
  logic [10:0] out_width;
  logic [10:0] out_height;
  logic [23:0] scale;
  logic [62:0] mean_values;
  logic [62:0] inv_std_values;

  logic [9:0]  sw, sh;
  logic [10:0] ow, oh;
  logic [brn_pkg::REM_BITS-1:0] den_x, den_y;

  // divider pipeline
  dstage_t ds [0:DS];
  logic    ds_vld [0:DS];
  dstage_t ds_in;
  logic [brn_pkg::NUM_BITS-1:0] ax, ay;
  logic    adv, take, in_acc;

  // sequencer
  logic        s_vld, s_op, s_ok;
  logic [1:0]  s_cnt;
  logic [23:0] s_rgb;
  logic [brn_pkg::ADDR_BITS-1:0] s_waddr;
  logic [brn_pkg::COL_BITS-1:0]  s_left, s_right;
  logic [brn_pkg::ROW_BITS-1:0]  s_top, s_bot;
  logic [15:0] s_wx, s_wy;
  logic [9:0]  s_x, s_y;
  logic        rd_issue, s_done, s_free, mem_we, start_ok;
  logic [brn_pkg::ADDR_BITS-1:0] raddr, maddr;

  // tail geometry
  logic [brn_pkg::QUOT_BITS-1:0] sx, sy;
  logic [9:0]  lft, rgt, tp, bt;
  logic [9:0]  sxi, syi, swm1, shm1;
  logic [brn_pkg::QUOT_BITS-1:0] wxf, wyf;

  // frame store
  logic [23:0] store [0:brn_pkg::STORE_DEPTH-1];
  logic [23:0] mem_rd;
  logic        rd_v;
  logic [1:0]  rd_k;
  logic [23:0] nb [0:2];
  logic [15:0] g_wx, g_wy;
  logic [9:0]  g_x, g_y;
  logic        m_go;

  // math pipeline
  logic [brn_pkg::MATH_DEPTH:1] m_vld;
  logic [19:0]        pidx [1:brn_pkg::MATH_DEPTH];
  logic signed [25:0] m1_tv [0:2];
  logic signed [25:0] m1_bv [0:2];
  logic signed [41:0] m2_v  [0:2];
  logic [23:0]        m3_v16 [0:2];
  logic [47:0]        m4_prod [0:2];
  logic signed [28:0] m5_d [0:2];
  logic signed [49:0] m6_e [0:2];
  logic signed [23:0] m7_r [0:2];
  logic signed [25:0] c_tv [0:2];
  logic signed [25:0] c_bv [0:2];
  logic signed [41:0] c_v  [0:2];
  logic [23:0]        c_v16 [0:2];
  logic [48:0]        c_psum [0:2];
  logic signed [28:0] c_d [0:2];
  logic signed [34:0] c_t [0:2];
  logic signed [23:0] c_r [0:2];
  logic [20:0]        c_pidx;

  // result buffer
  brn_pkg::result_t fifo [0:brn_pkg::FIFO_DEPTH-1];
  logic [brn_pkg::FIFO_PTR-1:0] wr_ptr, rd_ptr;
  logic [brn_pkg::FIFO_PTR:0]   f_cnt, cr_used;
  logic out_pop;

  // one restoring division step for each coordinate
  function automatic dstage_t div_next(input dstage_t s, input logic [11:0] dxv,
                                       input logic [11:0] dyv);
    dstage_t n;
    logic [12:0] r2x, r2y;
    n   = s;
    r2x = {s.rx, s.lx[brn_pkg::LOW_BITS-1]};
    r2y = {s.ry, s.ly[brn_pkg::LOW_BITS-1]};
    n.lx = s.lx << 1;
    n.ly = s.ly << 1;
    if (r2x >= {1'b0, dxv}) begin
      n.rx = 12'(r2x - {1'b0, dxv});
      n.qx = {s.qx[brn_pkg::QUOT_BITS-2:0], 1'b1};
    end else begin
      n.rx = r2x[11:0];
      n.qx = {s.qx[brn_pkg::QUOT_BITS-2:0], 1'b0};
    end
    if (r2y >= {1'b0, dyv}) begin
      n.ry = 12'(r2y - {1'b0, dyv});
      n.qy = {s.qy[brn_pkg::QUOT_BITS-2:0], 1'b1};
    end else begin
      n.ry = r2y[11:0];
      n.qy = {s.qy[brn_pkg::QUOT_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

  // configuration writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= brn_pkg::FMT_BGR8;
      src_width      <= 10'd512;
      src_height     <= 10'd512;
      out_width      <= 11'd224;
      out_height     <= 11'd224;
      scale          <= 24'd65536;
      mean_values    <= '0;
      inv_std_values <= '0;
    end else if (cfg_wr.valid) begin
      case (brn_pkg::reg_idx_t'(cfg_wr.index))
        brn_pkg::REG_PIXEL_FORMAT: pixel_format   <= cfg_wr.data[1:0];
        brn_pkg::REG_SRC_WIDTH:    src_width      <= cfg_wr.data[9:0];
        brn_pkg::REG_SRC_HEIGHT:   src_height     <= cfg_wr.data[9:0];
        brn_pkg::REG_OUT_WIDTH:    out_width      <= cfg_wr.data[10:0];
        brn_pkg::REG_OUT_HEIGHT:   out_height     <= cfg_wr.data[10:0];
        brn_pkg::REG_SCALE:        scale          <= cfg_wr.data[23:0];
        brn_pkg::REG_MEAN:         mean_values    <= cfg_wr.data;
        brn_pkg::REG_INV_STD:      inv_std_values <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign sw    = brn_pkg::clamp_src(src_width);
  assign sh    = brn_pkg::clamp_src(src_height);
  assign ow    = brn_pkg::clamp_out(out_width);
  assign oh    = brn_pkg::clamp_out(out_height);
  assign den_x = {ow, 1'b0};
  assign den_y = {oh, 1'b0};

  // input stage: color conversion, range check, numerator
  assign ax = 21'({in_item.x, 1'b1} * sw);
  assign ay = 21'({in_item.y, 1'b1} * sh);

  always_comb begin
    ds_in    = '0;
    ds_in.op = in_item.op;
    ds_in.x  = in_item.x;
    ds_in.y  = in_item.y;
    if (in_item.op == brn_pkg::OP_SAMPLE)
      ds_in.ok = ({1'b0, in_item.x} < ow) && ({1'b0, in_item.y} < oh);
    else
      ds_in.ok = (in_item.x < sw) && (in_item.y < sh);
    if (pixel_format == brn_pkg::FMT_GRAY8)
      ds_in.rgb = {in_item.byte0, in_item.byte0, in_item.byte0};
    else
      ds_in.rgb = {in_item.byte2, in_item.byte1, in_item.byte0};
    ds_in.rx = 12'(ax[brn_pkg::NUM_BITS-1:brn_pkg::LOW_BITS]);
    ds_in.ry = 12'(ay[brn_pkg::NUM_BITS-1:brn_pkg::LOW_BITS]);
    ds_in.lx = ax[brn_pkg::LOW_BITS-1:0];
    ds_in.ly = ay[brn_pkg::LOW_BITS-1:0];
  end

  assign in_item.ready = adv;
  assign in_acc        = in_item.valid && adv;

  // advance divider pipeline as one block
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DS; k++) ds_vld[k] <= 1'b0;
    end else if (adv) begin
      ds_vld[0] <= in_item.valid;
      for (int k = 1; k <= DS; k++) ds_vld[k] <= ds_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0] <= ds_in;
      for (int k = 1; k <= DS; k++) ds[k] <= div_next(ds[k-1], den_x, den_y);
    end
  end

  // tail: source position, neighbors and weights
  always_comb begin
    sx   = (ds[DS].qx > 26'd32768) ? ds[DS].qx - 26'd32768 : '0;
    sy   = (ds[DS].qy > 26'd32768) ? ds[DS].qy - 26'd32768 : '0;
    sxi  = sx[brn_pkg::QUOT_BITS-1:16];
    syi  = sy[brn_pkg::QUOT_BITS-1:16];
    swm1 = sw - 10'd1;
    shm1 = sh - 10'd1;
    lft  = (sxi > swm1) ? swm1 : sxi;
    tp   = (syi > shm1) ? shm1 : syi;
    rgt  = (lft + 10'd1 > swm1) ? swm1 : lft + 10'd1;
    bt   = (tp + 10'd1 > shm1) ? shm1 : tp + 10'd1;
    wxf  = sx - {lft, 16'h0};
    wyf  = sy - {tp, 16'h0};
  end

  // sequencer: one write per in-frame load, four reads per in-frame sample
  assign start_ok = cr_used < (brn_pkg::FIFO_PTR+1)'(brn_pkg::FIFO_DEPTH);
  assign rd_issue = s_vld && (s_op == brn_pkg::OP_SAMPLE) && s_ok
                    && ((s_cnt != 2'd0) || start_ok);
  assign mem_we   = s_vld && (s_op == brn_pkg::OP_LOAD) && s_ok;
  assign s_done   = s_vld && ((s_op == brn_pkg::OP_LOAD) || !s_ok
                              || (rd_issue && s_cnt == 2'd3));
  assign s_free   = !s_vld || s_done;
  assign take     = ds_vld[DS] && s_free;
  assign adv      = !ds_vld[DS] || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
      s_cnt <= 2'd0;
    end else begin
      if (take) begin
        s_vld <= 1'b1;
        s_cnt <= 2'd0;
      end else begin
        if (s_done) s_vld <= 1'b0;
        if (rd_issue) s_cnt <= s_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_op    <= ds[DS].op;
      s_ok    <= ds[DS].ok;
      s_rgb   <= ds[DS].rgb;
      s_waddr <= {ds[DS].y[brn_pkg::ROW_BITS-1:0], ds[DS].x[brn_pkg::COL_BITS-1:0]};
      s_left  <= lft[brn_pkg::COL_BITS-1:0];
      s_right <= rgt[brn_pkg::COL_BITS-1:0];
      s_top   <= tp[brn_pkg::ROW_BITS-1:0];
      s_bot   <= bt[brn_pkg::ROW_BITS-1:0];
      s_wx    <= wxf[15:0];
      s_wy    <= wyf[15:0];
      s_x     <= ds[DS].x;
      s_y     <= ds[DS].y;
    end
  end

  always_comb begin
    case (s_cnt)
      2'd0:    raddr = {s_top, s_left};
      2'd1:    raddr = {s_top, s_right};
      2'd2:    raddr = {s_bot, s_left};
      default: raddr = {s_bot, s_right};
    endcase
  end

  assign maddr = mem_we ? s_waddr : raddr;

  // single-port frame store
  always_ff @(posedge clk) begin
    if (mem_we) store[maddr] <= s_rgb;
    if (rd_issue) mem_rd <= store[maddr];
  end

  // collect neighbors as they return
  always_ff @(posedge clk) begin
    if (rst) rd_v <= 1'b0;
    else     rd_v <= rd_issue;
  end

  always_ff @(posedge clk) begin
    if (rd_issue) rd_k <= s_cnt;
    if (rd_issue && s_cnt == 2'd3) begin
      g_wx <= s_wx;
      g_wy <= s_wy;
      g_x  <= s_x;
      g_y  <= s_y;
    end
    if (rd_v) begin
      case (rd_k)
        2'd0:    nb[0] <= mem_rd;
        2'd1:    nb[1] <= mem_rd;
        2'd2:    nb[2] <= mem_rd;
        default: ;
      endcase
    end
  end

  assign m_go = rd_v && (rd_k == 2'd3);

  // blend and normalization datapath
  always_comb begin
    c_pidx = 21'(g_y * ow) + 21'(g_x);
    for (int c = 0; c < 3; c++) begin
      c_tv[c] = $signed({10'd0, nb[0][23-8*c -: 8], 8'd0} << 8)
              + 26'($signed({1'b0, nb[1][23-8*c -: 8]}) - $signed({1'b0, nb[0][23-8*c -: 8]}))
                * $signed({10'd0, g_wx});
      c_bv[c] = $signed({10'd0, nb[2][23-8*c -: 8], 8'd0} << 8)
              + 26'($signed({1'b0, mem_rd[23-8*c -: 8]}) - $signed({1'b0, nb[2][23-8*c -: 8]}))
                * $signed({10'd0, g_wx});
      c_v[c]  = $signed({m1_tv[c], 16'h0})
              + 42'(42'(m1_bv[c]) - 42'(m1_tv[c])) * $signed({26'd0, m1_wy_q});
      c_v16[c] = 24'((m2_v[c] + 42'sd32768) >>> 16);
      c_psum[c] = {1'b0, m4_prod[c]} + 49'd2097152;
      c_d[c]   = $signed({2'b0, c_psum[c][48:22]})
               - 29'($signed(mean_values[21*c +: 21]));
      c_t[c]   = 35'((m6_e[c] + 50'sd16384) >>> 15);
      if (c_t[c] > 35'sd8388607)       c_r[c] = 24'sh7FFFFF;
      else if (c_t[c] < -35'sd8388608) c_r[c] = -24'sh800000;
      else                             c_r[c] = c_t[c][23:0];
    end
  end

  logic [15:0] m1_wy_q;

  always_ff @(posedge clk) begin
    if (rst) m_vld <= '0;
    else     m_vld <= {m_vld[brn_pkg::MATH_DEPTH-1:1], m_go};
  end

  always_ff @(posedge clk) begin
    pidx[1] <= c_pidx[19:0];
    for (int k = 2; k <= brn_pkg::MATH_DEPTH; k++) pidx[k] <= pidx[k-1];
    m1_wy_q <= g_wy;
    for (int c = 0; c < 3; c++) begin
      m1_tv[c]   <= c_tv[c];
      m1_bv[c]   <= c_bv[c];
      m2_v[c]    <= c_v[c];
      m3_v16[c]  <= c_v16[c];
      m4_prod[c] <= m3_v16[c] * scale;
      m5_d[c]    <= c_d[c];
      m6_e[c]    <= m5_d[c] * $signed(inv_std_values[21*c +: 21]);
      m7_r[c]    <= c_r[c];
    end
  end

  // result buffer with credits reserved at sample start
  assign out_pop = out_item.valid && out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      f_cnt   <= '0;
      cr_used <= '0;
    end else begin
      if (m_vld[brn_pkg::MATH_DEPTH]) wr_ptr <= wr_ptr + 1'b1;
      if (out_pop) rd_ptr <= rd_ptr + 1'b1;
      f_cnt   <= f_cnt + (brn_pkg::FIFO_PTR+1)'(m_vld[brn_pkg::MATH_DEPTH])
                       - (brn_pkg::FIFO_PTR+1)'(out_pop);
      cr_used <= cr_used + (brn_pkg::FIFO_PTR+1)'(rd_issue && s_cnt == 2'd0)
                         - (brn_pkg::FIFO_PTR+1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (m_vld[brn_pkg::MATH_DEPTH]) begin
      fifo[wr_ptr].pixel_index <= pidx[brn_pkg::MATH_DEPTH];
      fifo[wr_ptr].red_value   <= m7_r[0];
      fifo[wr_ptr].green_value <= m7_r[1];
      fifo[wr_ptr].blue_value  <= m7_r[2];
    end
  end

  assign out_item.valid       = f_cnt != '0;
  assign out_item.pixel_index = fifo[rd_ptr].pixel_index;
  assign out_item.red_value   = fifo[rd_ptr].red_value;
  assign out_item.green_value = fifo[rd_ptr].green_value;
  assign out_item.blue_value  = fifo[rd_ptr].blue_value;

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    cr_used <= (brn_pkg::FIFO_PTR+1)'(brn_pkg::FIFO_DEPTH))
    else $error("credit counter overflow");

  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    m_vld[brn_pkg::MATH_DEPTH] |-> f_cnt < (brn_pkg::FIFO_PTR+1)'(brn_pkg::FIFO_DEPTH))
    else $error("result buffer written while full");

  a_port_single: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && rd_issue))
    else $error("frame store read and write in one cycle");

  a_buffer_le_credit: assert property (@(posedge clk) disable iff (rst)
    f_cnt <= cr_used)
    else $error("buffered results exceed reserved credits");
`endif

endmodule

FILE: sim/tb_bilinear_resize_normalize_top.sv
`timescale 1ns / 1ps
module tb_bilinear_resize_normalize_top;
  import brn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brn_in_if  in_if();
  brn_out_if out_if();
  brn_cfg_if cfg_if();

  bilinear_resize_normalize_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_if.sink),
    .out_item (out_if.source),
    .cfg_wr   (cfg_if.sink)
  );

  always #5 clk = ~clk;

  // shadow of the configuration registers
  logic [1:0]  fmt_q;
  logic [9:0]  src_w_q, src_h_q;
  logic [10:0] out_w_q, out_h_q;
  logic [23:0] scale_q;
  logic [62:0] mean_q, inv_std_q;

  // shadow frame store, red in bits 23:16
  logic [23:0] pixel_store [0:STORE_DEPTH-1];

  result_t pending_pixels[$];
  int      fail_count = 0;
  bit      no_idle = 1'b0;

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint eff_src(logic [9:0] v);
    if (v == 0) return 1;
    return (v > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : v;
  endfunction

  function automatic longint eff_out(logic [10:0] v);
    if (v == 0) return 1;
    return (v > MAX_OUT_DIM) ? MAX_OUT_DIM : v;
  endfunction

  // Q16 source position with half-pixel centers, clamped at zero
  function automatic longint map_coord(longint o, longint sdim, longint odim);
    longint q;
    q = (((2 * o + 1) * sdim) << 16) / (2 * odim);
    return (q > 32768) ? q - 32768 : 0;
  endfunction

  function automatic result_t resample_pixel(longint ox, longint oy);
    result_t res;
    longint sw, sh, ow, sx, sy, lf, tp, rt, bt, wx, wy;
    longint a, b, c, d, tv, bv, v, v16, p, diff, r;
    logic [23:0] tl, tr, bl, br;
    sw = eff_src(src_w_q);
    sh = eff_src(src_h_q);
    ow = eff_out(out_w_q);
    sx = map_coord(ox, sw, ow);
    sy = map_coord(oy, sh, eff_out(out_h_q));
    lf = sx >> 16;
    tp = sy >> 16;
    if (lf > sw - 1) lf = sw - 1;
    if (tp > sh - 1) tp = sh - 1;
    rt = (lf + 1 > sw - 1) ? sw - 1 : lf + 1;
    bt = (tp + 1 > sh - 1) ? sh - 1 : tp + 1;
    wx = sx - (lf << 16);
    wy = sy - (tp << 16);
    tl = pixel_store[tp * MAX_SRC_WIDTH + lf];
    tr = pixel_store[tp * MAX_SRC_WIDTH + rt];
    bl = pixel_store[bt * MAX_SRC_WIDTH + lf];
    br = pixel_store[bt * MAX_SRC_WIDTH + rt];
    res.pixel_index = 20'(oy * ow + ox);
    for (int ch = 0; ch < 3; ch++) begin
      a = tl[16 - 8 * ch +: 8];
      b = tr[16 - 8 * ch +: 8];
      c = bl[16 - 8 * ch +: 8];
      d = br[16 - 8 * ch +: 8];
      tv = a * 65536 + (b - a) * wx;
      bv = c * 65536 + (d - c) * wx;
      v = tv * 65536 + (bv - tv) * wy;
      v16 = (v + 32768) >>> 16;
      p = (v16 * longint'(scale_q) + (64'sd1 <<< 21)) >>> 22;
      diff = p - longint'($signed(mean_q[21 * ch +: 21]));
      r = (diff * longint'($signed(inv_std_q[21 * ch +: 21])) + 16384) >>> 15;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      case (ch)
        0: res.red_value = 24'(r);
        1: res.green_value = 24'(r);
        default: res.blue_value = 24'(r);
      endcase
    end
    return res;
  endfunction

  // Send one item and update the prediction once it is accepted
  task automatic send_item(op_t op, int x, int y, logic [7:0] b0, logic [7:0] b1,
                           logic [7:0] b2);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.op    = op;
    in_if.x     = 10'(x);
    in_if.y     = 10'(y);
    in_if.byte0 = b0;
    in_if.byte1 = b1;
    in_if.byte2 = b2;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if (op == OP_LOAD) begin
      if (x < eff_src(src_w_q) && y < eff_src(src_h_q))
        pixel_store[y * MAX_SRC_WIDTH + x] = (fmt_q == FMT_GRAY8) ? {b0, b0, b0} : {b2, b1, b0};
    end else if (x < eff_out(out_w_q) && y < eff_out(out_h_q)) begin
      pending_pixels.push_back(resample_pixel(x, y));
    end
  endtask

  // Release the input channel and let the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [62:0] data);
    @(negedge clk);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_PIXEL_FORMAT: fmt_q = data[1:0];
      REG_SRC_WIDTH:    src_w_q = data[9:0];
      REG_SRC_HEIGHT:   src_h_q = data[9:0];
      REG_OUT_WIDTH:    out_w_q = data[10:0];
      REG_OUT_HEIGHT:   out_h_q = data[10:0];
      REG_SCALE:        scale_q = data[23:0];
      REG_MEAN:         mean_q = data;
      default:          inv_std_q = data;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic setup(logic [1:0] fmt, int sw, int sh, int ow, int oh,
                       logic [23:0] scl, logic [62:0] mean, logic [62:0] inv);
    write_reg(REG_PIXEL_FORMAT, 63'(fmt));
    write_reg(REG_SRC_WIDTH, 63'(sw));
    write_reg(REG_SRC_HEIGHT, 63'(sh));
    write_reg(REG_OUT_WIDTH, 63'(ow));
    write_reg(REG_OUT_HEIGHT, 63'(oh));
    write_reg(REG_SCALE, 63'(scl));
    write_reg(REG_MEAN, mean);
    write_reg(REG_INV_STD, inv);
  endtask

  // Fill the whole effective source frame with random pixels
  task automatic fill_frame();
    for (int yy = 0; yy < eff_src(src_h_q); yy++)
      for (int xx = 0; xx < eff_src(src_w_q); xx++)
        send_item(OP_LOAD, xx, yy, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [62:0] rand63();
    return {31'($urandom), 32'($urandom)};
  endfunction

  task automatic random_samples(int count);
    int ow, oh;
    ow = eff_out(out_w_q);
    oh = eff_out(out_h_q);
    for (int i = 0; i < count; i++)
      send_item(OP_SAMPLE, $urandom_range(0, ow - 1), $urandom_range(0, oh - 1),
                8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Corners, extreme pixels, ignored loads and samples outside the frame
  task automatic test_directed();
    setup(FMT_BGR8, 4, 3, 7, 5, 24'd65536, 63'd0, {3{21'd32768}});
    fill_frame();
    send_item(OP_LOAD, 0, 0, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_LOAD, 3, 2, 8'h00, 8'h00, 8'h00);
    send_item(OP_LOAD, 1023, 0, 8'h12, 8'h34, 8'h56);
    send_item(OP_LOAD, 0, 1023, 8'h12, 8'h34, 8'h56);
    send_item(OP_SAMPLE, 0, 0, 8'h00, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 6, 4, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_SAMPLE, 3, 2, 8'h00, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 7, 0, 8'h00, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 0, 5, 8'h00, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 1023, 1023, 8'hFF, 8'hFF, 8'hFF);
    settle();
    // gray, BGR and undefined formats on the same frame
    for (int f = 0; f < 4; f++) begin
      write_reg(REG_PIXEL_FORMAT, 63'(f));
      send_item(OP_LOAD, 1, 1, 8'hA5, 8'h5A, 8'hC3);
      send_item(OP_SAMPLE, 3, 2, 8'h00, 8'h00, 8'h00);
      settle();
    end
  endtask

  // Zero and oversized dimension registers clamp to the legal range
  task automatic test_clamped_dims();
    setup(FMT_GRAY8, 0, 1000, 0, 2047, 24'd65536, 63'd0, {3{21'd32768}});
    fill_frame();
    random_samples(40);
    send_item(OP_SAMPLE, 0, 1023, 8'h00, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 1, 0, 8'h00, 8'h00, 8'h00);
    settle();
    setup(FMT_BGR8, 512, 1, 1024, 2, 24'd65536, 63'd0, {3{21'd32768}});
    fill_frame();
    random_samples(60);
    send_item(OP_SAMPLE, 1023, 1, 8'h00, 8'h00, 8'h00);
    settle();
  endtask

  // Extreme scale, mean and deviation drive every channel into saturation
  task automatic test_saturation();
    setup(2'd2, 3, 3, 2, 2, 24'hFFFFFF, {21'h100000, 21'h0FFFFF, 21'h100000},
          {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
    fill_frame();
    random_samples(8);
    settle();
    write_reg(REG_SCALE, 63'd0);
    write_reg(REG_MEAN, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
    random_samples(6);
    settle();
  endtask

  // Random settings, full frames, then mostly samples with some reloads and out-of-frame items
  task automatic test_random();
    int r;
    for (int ph = 0; ph < 14; ph++) begin
      no_idle = (ph % 5 == 4);
      setup(2'($urandom), $urandom_range(1, 16), $urandom_range(1, 16),
            $urandom_range(1, 40), $urandom_range(1, 40), 24'($urandom),
            rand63(), rand63());
      fill_frame();
      for (int i = 0; i < 120; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          random_samples(1);
        else if (r < 92)
          send_item(OP_LOAD, $urandom_range(0, eff_src(src_w_q) - 1),
                    $urandom_range(0, eff_src(src_h_q) - 1),
                    8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_item(op_t'($urandom_range(0, 1)), $urandom_range(40, 1023),
                    $urandom_range(0, 1023), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      settle();
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, long ones now and then
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(1, 3);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result idx=%0d", $time, out_if.pixel_index);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (want.pixel_index !== out_if.pixel_index ||
            want.red_value !== out_if.red_value ||
            want.green_value !== out_if.green_value ||
            want.blue_value !== out_if.blue_value) begin
          $display("%0t: expected idx=%0d rgb=%0d %0d %0d, actual idx=%0d rgb=%0d %0d %0d",
                   $time, want.pixel_index, want.red_value, want.green_value,
                   want.blue_value, out_if.pixel_index, out_if.red_value,
                   out_if.green_value, out_if.blue_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.x = '0;
    in_if.y = '0;
    in_if.byte0 = '0;
    in_if.byte1 = '0;
    in_if.byte2 = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PIXEL_FORMAT;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    fmt_q = FMT_BGR8;
    src_w_q = 10'd512;
    src_h_q = 10'd512;
    out_w_q = 11'd224;
    out_h_q = 11'd224;
    scale_q = 24'd65536;
    mean_q = '0;
    inv_std_q = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_clamped_dims();
    test_saturation();
    test_random();
    settle();
    if (fail_count == 0 && pending_pixels.size() == 0)
      $display("bilinear_resize_normalize_top: match");
    else
      $display("bilinear_resize_normalize_top: mismatch");
    $finish;
  end

  initial begin
    #200ms;
    $display("bilinear_resize_normalize_top: mismatch");
    $finish;
  end

endmodule

FILE: bilinear_resize_normalize_top.f
rtl/brn_pkg.sv
rtl/brn_in_if.sv
rtl/brn_out_if.sv
rtl/brn_cfg_if.sv
rtl/bilinear_resize_normalize_top.sv
sim/tb_bilinear_resize_normalize_top.sv
